### hdl/sbsv_pkg.sv
// Shared types, codes and constants for the sprite bank stream validator.
package sbsv_pkg;

  localparam int unsigned DEF_MAX_BANKS   = 16;
  localparam logic [15:0] DEF_MAX_SPRITES = 16'd1024;
  localparam logic [15:0] MAX_ROW_BYTES   = 16'd8191;
  localparam logic [15:0] MAX_DEPTH       = 16'd5;
  localparam int unsigned HDR_LAST_IDX    = 9;
  localparam int unsigned CNT_HI_IDX      = 4;

  // Input opcodes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  // Result kinds.
  localparam logic KIND_BANK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Summary status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_BANK   = 2'd1;
  localparam logic [1:0] ST_BAD_COUNT = 2'd2;

  // Record header byte positions.
  localparam logic [3:0] HB_WIDTH_HI  = 4'd0;
  localparam logic [3:0] HB_WIDTH_LO  = 4'd1;
  localparam logic [3:0] HB_HEIGHT_HI = 4'd2;
  localparam logic [3:0] HB_HEIGHT_LO = 4'd3;
  localparam logic [3:0] HB_DEPTH_HI  = 4'd4;
  localparam logic [3:0] HB_DEPTH_LO  = 4'd5;
  localparam logic [3:0] HB_FLAGS_HI  = 4'd6;

  typedef struct packed {
    logic        kind;
    logic [3:0]  bank_number;
    logic [31:0] bank_offset;
    logic [31:0] bank_bytes;
    logic [15:0] first_sprite;
    logic [15:0] sprite_count;
    logic [1:0]  status;
    logic [4:0]  bank_total;
    logic [15:0] sprite_total;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       step;      // a file byte transaction was taken
    logic       eof;       // give the summary and clear the parse state
    logic [3:0] idx;       // current header byte position
    logic       cnt_hi;
    logic       cnt_lo;
    logic       hdr_load;
    logic       mul1;
    logic       mul2;
    logic       dec_data;
    logic       fin_rec;
    logic       fin_bank;
    logic       fail;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic magic_ok;
    logic cnt_zero;
    logic hdr_ok;
    logic data_last;
    logic pad_pending;
    logic rec_last;
    logic bank_ok;
    logic banks_full;
  } sts_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h41;
      2'd1:    b = 8'h6D;
      2'd2:    b = 8'h53;
      default: b = 8'h70;
    endcase
    return b;
  endfunction

endpackage

### hdl/sbsv_outq.sv
// Two-entry result queue between the parser and the output channel.
module sbsv_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sbsv_pkg::res_t push_data,
  input  logic          pop,
  output sbsv_pkg::res_t head,
  output logic          not_empty,
  output logic          has_space
);
  import sbsv_pkg::*;

  res_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign not_empty = (count_r != 2'd0);
  assign has_space = (count_r != 2'd2);
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hdl/sbsv_ctrl.sv
// Parse controller: bank and record phases, header byte counter, handshake.
module sbsv_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  input  logic          q_space,
  input  sbsv_pkg::sts_t sts,
  output logic          in_ready,
  output sbsv_pkg::cmd_t cmd
);
  import sbsv_pkg::*;

  typedef enum logic [6:0] {
    S_BANK = 7'b0000001,
    S_REC  = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_MUL2 = 7'b0001000,
    S_DATA = 7'b0010000,
    S_PAD  = 7'b0100000,
    S_STOP = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] hcnt_r, hcnt_nxt;
  logic       take;
  logic       rec_done;

  assign in_ready = q_space && (state_r != S_MUL1) && (state_r != S_MUL2);
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    hcnt_nxt  = hcnt_r;
    cmd       = '0;
    cmd.idx   = hcnt_r;
    rec_done  = 1'b0;

    unique case (state_r)
      S_MUL1: begin
        if (sts.hdr_ok) begin
          cmd.mul1  = 1'b1;
          state_nxt = S_MUL2;
        end else begin
          state_nxt = S_STOP;
        end
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_DATA;
      end
      default: begin
        if (take && in_op == OP_EOF) begin
          cmd.eof   = 1'b1;
          state_nxt = S_BANK;
          hcnt_nxt  = '0;
        end else if (take) begin
          cmd.step = 1'b1;
          unique case (state_r)
            S_BANK: begin
              if (hcnt_r < 4'(CNT_HI_IDX)) begin
                if (sts.magic_ok) begin
                  hcnt_nxt = hcnt_r + 4'd1;
                end else begin
                  state_nxt = S_STOP;
                end
              end else if (hcnt_r == 4'(CNT_HI_IDX)) begin
                cmd.cnt_hi = 1'b1;
                hcnt_nxt   = hcnt_r + 4'd1;
              end else begin
                cmd.cnt_lo = 1'b1;
                hcnt_nxt   = '0;
                if (sts.cnt_zero) begin
                  // An empty bank always fails the sprite count check.
                  cmd.fail  = 1'b1;
                  state_nxt = S_STOP;
                end else begin
                  state_nxt = S_REC;
                end
              end
            end
            S_REC: begin
              cmd.hdr_load = 1'b1;
              if (hcnt_r >= 4'(HDR_LAST_IDX)) begin
                hcnt_nxt  = '0;
                state_nxt = S_MUL1;
              end else begin
                hcnt_nxt = hcnt_r + 4'd1;
              end
            end
            S_DATA: begin
              cmd.dec_data = 1'b1;
              if (sts.data_last) begin
                if (sts.pad_pending) begin
                  state_nxt = S_PAD;
                end else begin
                  rec_done = 1'b1;
                end
              end
            end
            S_PAD: begin
              rec_done = 1'b1;
            end
            default: begin
            end
          endcase

          if (rec_done) begin
            cmd.fin_rec = 1'b1;
            hcnt_nxt    = '0;
            if (sts.rec_last) begin
              cmd.fin_bank = 1'b1;
              if (sts.bank_ok && !sts.banks_full) begin
                state_nxt = S_BANK;
              end else begin
                state_nxt = S_STOP;
              end
            end else begin
              state_nxt = S_REC;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BANK;
      hcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      hcnt_r  <= hcnt_nxt;
    end
  end

endmodule

### hdl/sbsv_dp.sv
// Parse datapath: header words, length arithmetic, counters and result forming.
module sbsv_dp #(
  parameter int unsigned MAX_BANKS = sbsv_pkg::DEF_MAX_BANKS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     data_byte,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_value,
  input  sbsv_pkg::cmd_t cmd,
  output sbsv_pkg::sts_t sts,
  output logic           push,
  output sbsv_pkg::res_t push_data
);
  import sbsv_pkg::*;

  localparam int unsigned BW = $clog2(MAX_BANKS + 1);

  logic [15:0]   max_spr_r, max_spr_nxt;
  logic [15:0]   width_r, width_nxt;
  logic [15:0]   height_r, height_nxt;
  logic [15:0]   depth_r, depth_nxt;
  logic          mask_r, mask_nxt;
  logic [15:0]   rec_left_r, rec_left_nxt;
  logic [15:0]   rec_cnt_r, rec_cnt_nxt;
  logic [31:0]   data_left_r, data_left_nxt;
  logic          pad_r, pad_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [31:0]   bank_start_r, bank_start_nxt;
  logic [BW-1:0] banks_r, banks_nxt;
  logic [15:0]   sprites_r, sprites_nxt;
  logic          failed_r, failed_nxt;
  logic [28:0]   prod_r, prod_nxt;

  logic [15:0]   row_bytes;
  logic [2:0]    planes;
  logic [31:0]   total_bytes;
  logic [16:0]   spr_sum;

  // Bytes per row: two per word, one less when the odd-width bit is set.
  assign row_bytes   = {width_r[14:0], 1'b0} - {15'd0, width_r[15]};
  assign planes      = depth_r[2:0] + {2'd0, mask_r};
  assign total_bytes = prod_r * planes;
  assign spr_sum     = {1'b0, sprites_r} + {1'b0, rec_cnt_r};

  always_comb begin
    sts.magic_ok    = (data_byte == magic_byte(cmd.idx[1:0]));
    sts.cnt_zero    = (rec_cnt_r[15:8] == 8'd0) && (data_byte == 8'd0);
    sts.hdr_ok      = (width_r[14:0] != 15'd0) && (row_bytes <= MAX_ROW_BYTES) &&
                      (height_r != 16'd0) && (depth_r != 16'd0) &&
                      (depth_r <= MAX_DEPTH);
    sts.data_last   = (data_left_r <= 32'd1);
    sts.pad_pending = pad_r;
    sts.rec_last    = (rec_left_r == 16'd1);
    sts.bank_ok     = (rec_cnt_r != 16'd0) && (spr_sum <= {1'b0, max_spr_r});
    sts.banks_full  = (banks_r == BW'(MAX_BANKS - 1));
  end

  always_comb begin
    max_spr_nxt    = cfg_we ? cfg_value : max_spr_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    depth_nxt      = depth_r;
    mask_nxt       = mask_r;
    rec_left_nxt   = rec_left_r;
    rec_cnt_nxt    = rec_cnt_r;
    data_left_nxt  = data_left_r;
    pad_nxt        = pad_r;
    pos_nxt        = pos_r;
    bank_start_nxt = bank_start_r;
    banks_nxt      = banks_r;
    sprites_nxt    = sprites_r;
    failed_nxt     = failed_r;
    prod_nxt       = prod_r;
    push           = 1'b0;
    push_data      = '0;

    if (cmd.step) begin
      pos_nxt = (&pos_r) ? pos_r : pos_r + 32'd1;
    end
    if (cmd.cnt_hi) begin
      rec_cnt_nxt = {data_byte, 8'd0};
    end
    if (cmd.cnt_lo) begin
      rec_cnt_nxt  = {rec_cnt_r[15:8], data_byte};
      rec_left_nxt = {rec_cnt_r[15:8], data_byte};
    end
    if (cmd.hdr_load) begin
      case (cmd.idx)
        HB_WIDTH_HI:  width_nxt  = {data_byte, 8'd0};
        HB_WIDTH_LO:  width_nxt  = {width_r[15:8], data_byte};
        HB_HEIGHT_HI: height_nxt = {data_byte, 8'd0};
        HB_HEIGHT_LO: height_nxt = {height_r[15:8], data_byte};
        HB_DEPTH_HI:  depth_nxt  = {data_byte, 8'd0};
        HB_DEPTH_LO:  depth_nxt  = {depth_r[15:8], data_byte};
        HB_FLAGS_HI:  mask_nxt   = data_byte[7];
        default: begin
        end
      endcase
    end
    if (cmd.mul1) begin
      prod_nxt = row_bytes[12:0] * height_r;
    end
    if (cmd.mul2) begin
      data_left_nxt = total_bytes;
      pad_nxt       = total_bytes[0];
    end
    if (cmd.dec_data && data_left_r != 32'd0) begin
      data_left_nxt = data_left_r - 32'd1;
    end
    if (cmd.fin_rec) begin
      rec_left_nxt = rec_left_r - 16'd1;
      pad_nxt      = 1'b0;
    end
    if (cmd.fail) begin
      failed_nxt = 1'b1;
    end
    if (cmd.fin_bank) begin
      if (sts.bank_ok) begin
        push                   = 1'b1;
        push_data.kind         = KIND_BANK;
        push_data.bank_number  = 4'(banks_r);
        push_data.bank_offset  = bank_start_r;
        push_data.bank_bytes   = pos_nxt - bank_start_r;
        push_data.first_sprite = sprites_r;
        push_data.sprite_count = rec_cnt_r;
        banks_nxt              = banks_r + BW'(1);
        sprites_nxt            = spr_sum[15:0];
        bank_start_nxt         = pos_nxt;
      end else begin
        failed_nxt = 1'b1;
      end
    end

    if (cmd.eof) begin
      push           = 1'b1;
      push_data.kind = KIND_SUMMARY;
      if (failed_r) begin
        push_data.status = ST_BAD_COUNT;
      end else begin
        push_data.status       = (banks_r == '0) ? ST_NO_BANK : ST_OK;
        push_data.bank_total   = 5'(banks_r);
        push_data.sprite_total = sprites_r;
      end
      width_nxt      = '0;
      height_nxt     = '0;
      depth_nxt      = '0;
      mask_nxt       = 1'b0;
      rec_left_nxt   = '0;
      rec_cnt_nxt    = '0;
      data_left_nxt  = '0;
      pad_nxt        = 1'b0;
      pos_nxt        = '0;
      bank_start_nxt = '0;
      banks_nxt      = '0;
      sprites_nxt    = '0;
      failed_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_spr_r    <= DEF_MAX_SPRITES;
      width_r      <= '0;
      height_r     <= '0;
      depth_r      <= '0;
      mask_r       <= 1'b0;
      rec_left_r   <= '0;
      rec_cnt_r    <= '0;
      data_left_r  <= '0;
      pad_r        <= 1'b0;
      pos_r        <= '0;
      bank_start_r <= '0;
      banks_r      <= '0;
      sprites_r    <= '0;
      failed_r     <= 1'b0;
    end else begin
      max_spr_r    <= max_spr_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      depth_r      <= depth_nxt;
      mask_r       <= mask_nxt;
      rec_left_r   <= rec_left_nxt;
      rec_cnt_r    <= rec_cnt_nxt;
      data_left_r  <= data_left_nxt;
      pad_r        <= pad_nxt;
      pos_r        <= pos_nxt;
      bank_start_r <= bank_start_nxt;
      banks_r      <= banks_nxt;
      sprites_r    <= sprites_nxt;
      failed_r     <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

### hdl/sprite_bank_stream_validator.sv
// Top level of the sprite bank stream validator.
// Takes a sprite bank file one byte per input transaction (tuser 0) and an
// end-of-file marker (tuser 1), and gives one result per accepted bank plus
// a summary at end of file, after which it is ready for a new file. A byte
// is taken every cycle, except that after the last byte of each record
// header the input is held off while the plane data length is formed in
// two multiply steps, and also stalls while the two-entry result queue is
// full. The user must write max_sprites (cfg port, reset value 1024) only
// while the block is idle; the block itself does not enforce this.
module sprite_bank_stream_validator #(
  parameter int unsigned MAX_BANKS = sbsv_pkg::DEF_MAX_BANKS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] bank_number, [35:4] bank_offset, [67:36] bank_bytes,
  // [83:68] first_sprite, [99:84] sprite_count, [101:100] status,
  // [106:102] bank_total, [122:107] sprite_total, [127:123] zero
  output logic [127:0] out_tdata,
  output logic         out_tuser,  // [0] result_kind
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data    // max_sprites
);
  import sbsv_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t push_data;
  res_t head;
  logic push;
  logic q_space;

  assign cfg_ready = 1'b1;

  sbsv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .q_space  (q_space),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  sbsv_dp #(
    .MAX_BANKS (MAX_BANKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .push      (push),
    .push_data (push_data)
  );

  sbsv_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (out_tready),
    .head      (head),
    .not_empty (out_tvalid),
    .has_space (q_space)
  );

  assign out_tuser = head.kind;
  assign out_tdata = {5'd0, head.sprite_total, head.bank_total, head.status,
                      head.sprite_count, head.first_sprite, head.bank_bytes,
                      head.bank_offset, head.bank_number};

endmodule
